[design/ipfl_pkg.sv]
// ----------------------------------------------------------------------------
// ipfl_pkg
// shared constants, codes and types of the address and tcp flag filter
// ----------------------------------------------------------------------------
package ipfl_pkg;

    localparam int ALLOW_DEPTH = 1024;
    localparam int BLOCK_DEPTH = 1024;
    localparam int A_AW        = (ALLOW_DEPTH > 1) ? $clog2(ALLOW_DEPTH) : 1;
    localparam int B_AW        = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;
    localparam int SCAN_DEPTH  = (ALLOW_DEPTH > BLOCK_DEPTH) ? ALLOW_DEPTH : BLOCK_DEPTH;
    localparam int IW          = (SCAN_DEPTH > 1) ? $clog2(SCAN_DEPTH) : 1;
    localparam int ENTRY_W     = 33;

    localparam logic [15:0] ETH_IPV4       = 16'h0800;
    localparam logic [15:0] FRAG_OFS_MASK  = 16'h1FFF;
    localparam logic [15:0] FRAG_MF_BIT    = 16'h2000;
    localparam logic [15:0] MIN_FRAG_RESET = 16'd1280;
    localparam logic [7:0]  PROTO_TCP      = 8'h06;
    localparam logic [7:0]  FL_FIN_PSH_URG = 8'h29;
    localparam logic [7:0]  FL_SYN_FIN     = 8'h03;
    localparam logic [7:0]  FL_FIN_ACK     = 8'h11;
    localparam logic [7:0]  FL_FIN         = 8'h01;
    localparam logic [7:0]  FL_SYN_RST     = 8'h06;
    localparam logic [7:0]  LEN_ETH        = 8'd14;
    localparam logic [7:0]  LEN_IP_MIN     = 8'd34;
    localparam logic [6:0]  IDX_MAX        = 7'd127;

    typedef enum logic [2:0] {
        OP_FRAME     = 3'd0,
        OP_ADD_ALLOW = 3'd1,
        OP_ADD_BLOCK = 3'd2,
        OP_DEL_ALLOW = 3'd3,
        OP_DEL_BLOCK = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        CAUSE_CLEAN     = 3'd0,
        CAUSE_ALLOWED   = 3'd1,
        CAUSE_BLOCKED   = 3'd2,
        CAUSE_SHORT_FRG = 3'd3,
        CAUSE_MALFORMED = 3'd4,
        CAUSE_BAD_FLAGS = 3'd5,
        CAUSE_NOT_IPV4  = 3'd6
    } t_cause;

    typedef enum logic [1:0] {
        TS_DONE      = 2'd0,
        TS_FULL      = 2'd1,
        TS_NOT_FOUND = 2'd2
    } t_tstat;

    typedef enum logic [1:0] {
        SK_LOOKUP,
        SK_ADD,
        SK_REMOVE
    } t_scan_kind;

    typedef enum logic [2:0] {
        SC_CLEAR,
        SC_IDLE,
        SC_RUN,
        SC_DRAIN,
        SC_COMMIT
    } t_scan_state;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [7:0]  len;
        logic [15:0] ether;
        logic [31:0] src;
        logic [3:0]  hw;
        logic [15:0] frag;
        logic [15:0] tot_len;
        logic [7:0]  proto;
        logic [7:0]  flags;
    } t_hdr;

    typedef struct packed {
        logic        go;
        t_scan_kind  kind;
        logic        blk;
        logic [31:0] key;
    } t_scan_req;

    typedef struct packed {
        logic   idle;
        logic   done;
        logic   hit_allow;
        logic   hit_block;
        t_tstat status;
    } t_scan_rsp;

endpackage

[design/ipfl_ram.sv]
// ----------------------------------------------------------------------------
// ipfl_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module ipfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[design/ipfl_hdr.sv]
// ----------------------------------------------------------------------------
// ipfl_hdr
// byte-wise header field capture, gives the fields with the current beat applied
// ----------------------------------------------------------------------------
module ipfl_hdr (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  logic [7:0]    i_byte,
    input  logic          i_last,
    output ipfl_pkg::t_hdr o_hdr
);
    import ipfl_pkg::*;

    logic [6:0] r_idx, n_idx;
    t_hdr       r_f, n_f;
    logic [7:0] flag_pos;

    always_comb begin
        n_f      = r_f;
        flag_pos = 8'd27 + {2'b00, r_f.hw, 2'b00};
        unique case (r_idx)
            7'd12:   n_f.ether[15:8]   = i_byte;
            7'd13:   n_f.ether[7:0]    = i_byte;
            7'd14:   n_f.hw            = i_byte[3:0];
            7'd16:   n_f.tot_len[15:8] = i_byte;
            7'd17:   n_f.tot_len[7:0]  = i_byte;
            7'd20:   n_f.frag[15:8]    = i_byte;
            7'd21:   n_f.frag[7:0]     = i_byte;
            7'd23:   n_f.proto         = i_byte;
            7'd26:   n_f.src[31:24]    = i_byte;
            7'd27:   n_f.src[23:16]    = i_byte;
            7'd28:   n_f.src[15:8]     = i_byte;
            7'd29:   n_f.src[7:0]      = i_byte;
            default: ;
        endcase
        // flag byte sits 13 bytes into the tcp header
        if (r_idx > 7'd14 && {1'b0, r_idx} == flag_pos) begin
            n_f.flags = i_byte;
        end
        n_idx     = (r_idx < IDX_MAX) ? r_idx + 7'd1 : r_idx;
        n_f.len   = (n_idx >= IDX_MAX) ? 8'd128 : {1'b0, n_idx};
        o_hdr     = n_f;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_f   <= '0;
        end else if (i_take) begin
            if (i_last) begin
                r_idx <= '0;
                r_f   <= '0;
            end else begin
                r_idx <= n_idx;
                r_f   <= n_f;
            end
        end
    end

endmodule

[design/ipfl_scan.sv]
// ----------------------------------------------------------------------------
// ipfl_scan
// list engine: one compare walks both lists entry by entry, then commits
// ----------------------------------------------------------------------------
module ipfl_scan (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ipfl_pkg::t_scan_req i_req,
    output ipfl_pkg::t_scan_rsp o_rsp
);
    import ipfl_pkg::*;

    t_scan_state r_state, n_state;
    logic [IW-1:0]   r_idx;
    logic [IW-1:0]   r_pidx;
    logic            r_pvalid;
    t_scan_kind      r_kind;
    logic            r_blk;
    logic [31:0]     r_key;
    logic            r_hit_a, r_hit_b, r_free_a, r_free_b;
    logic [A_AW-1:0] r_hidx_a, r_fidx_a;
    logic [B_AW-1:0] r_hidx_b, r_fidx_b;

    logic [ENTRY_W-1:0] rd_a, rd_b, wdata;
    logic               we_a, we_b;
    logic [A_AW-1:0]    waddr_a;
    logic [B_AW-1:0]    waddr_b;
    logic               in_a, in_b, p_in_a, p_in_b, idx_last;
    logic               m_a, m_b, f_a, f_b, hit, free;
    t_tstat             status;

    ipfl_ram #(.WIDTH(ENTRY_W), .DEPTH(ALLOW_DEPTH)) u_allow (
        .i_clk  (i_clk),
        .i_we   (we_a),
        .i_waddr(waddr_a),
        .i_wdata(wdata),
        .i_raddr(r_idx[A_AW-1:0]),
        .o_rdata(rd_a)
    );

    ipfl_ram #(.WIDTH(ENTRY_W), .DEPTH(BLOCK_DEPTH)) u_block (
        .i_clk  (i_clk),
        .i_we   (we_b),
        .i_waddr(waddr_b),
        .i_wdata(wdata),
        .i_raddr(r_idx[B_AW-1:0]),
        .o_rdata(rd_b)
    );

    always_comb begin
        in_a     = {1'b0, r_idx} < (IW+1)'(ALLOW_DEPTH);
        in_b     = {1'b0, r_idx} < (IW+1)'(BLOCK_DEPTH);
        p_in_a   = {1'b0, r_pidx} < (IW+1)'(ALLOW_DEPTH);
        p_in_b   = {1'b0, r_pidx} < (IW+1)'(BLOCK_DEPTH);
        idx_last = r_idx == IW'(SCAN_DEPTH - 1);
        m_a      = r_pvalid && p_in_a && rd_a[32] && rd_a[31:0] == r_key;
        m_b      = r_pvalid && p_in_b && rd_b[32] && rd_b[31:0] == r_key;
        f_a      = r_pvalid && p_in_a && !rd_a[32];
        f_b      = r_pvalid && p_in_b && !rd_b[32];
        hit      = r_blk ? r_hit_b : r_hit_a;
        free     = r_blk ? r_free_b : r_free_a;

        n_state  = r_state;
        we_a     = 1'b0;
        we_b     = 1'b0;
        waddr_a  = r_idx[A_AW-1:0];
        waddr_b  = r_idx[B_AW-1:0];
        wdata    = '0;
        status   = TS_DONE;

        unique case (r_state)
            SC_CLEAR: begin
                we_a = in_a;
                we_b = in_b;
                if (idx_last) begin
                    n_state = SC_IDLE;
                end
            end
            SC_IDLE: begin
                if (i_req.go) begin
                    n_state = SC_RUN;
                end
            end
            SC_RUN: begin
                if (idx_last) begin
                    n_state = SC_DRAIN;
                end
            end
            SC_DRAIN: begin
                n_state = SC_COMMIT;
            end
            SC_COMMIT: begin
                n_state = SC_IDLE;
                unique case (r_kind)
                    SK_ADD: begin
                        if (!hit) begin
                            if (free) begin
                                wdata   = {1'b1, r_key};
                                we_a    = !r_blk;
                                we_b    = r_blk;
                                waddr_a = r_fidx_a;
                                waddr_b = r_fidx_b;
                            end else begin
                                status = TS_FULL;
                            end
                        end
                    end
                    SK_REMOVE: begin
                        if (hit) begin
                            we_a    = !r_blk;
                            we_b    = r_blk;
                            waddr_a = r_hidx_a;
                            waddr_b = r_hidx_b;
                        end else begin
                            status = TS_NOT_FOUND;
                        end
                    end
                    default: ;
                endcase
            end
            default: n_state = SC_IDLE;
        endcase

        o_rsp.idle      = r_state == SC_IDLE;
        o_rsp.done      = r_state == SC_COMMIT;
        o_rsp.hit_allow = r_hit_a;
        o_rsp.hit_block = r_hit_b;
        o_rsp.status    = status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= SC_CLEAR;
            r_idx    <= '0;
            r_pvalid <= 1'b0;
            r_hit_a  <= 1'b0;
            r_hit_b  <= 1'b0;
            r_free_a <= 1'b0;
            r_free_b <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pvalid <= r_state == SC_RUN;
            if (r_state == SC_CLEAR || r_state == SC_RUN) begin
                r_idx <= idx_last ? '0 : r_idx + IW'(1);
            end
            if (r_state == SC_IDLE && i_req.go) begin
                r_hit_a  <= 1'b0;
                r_hit_b  <= 1'b0;
                r_free_a <= 1'b0;
                r_free_b <= 1'b0;
            end else begin
                if (m_a) r_hit_a <= 1'b1;
                if (m_b) r_hit_b <= 1'b1;
                if (f_a) r_free_a <= 1'b1;
                if (f_b) r_free_b <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx <= r_idx;
        if (r_state == SC_IDLE && i_req.go) begin
            r_kind <= i_req.kind;
            r_blk  <= i_req.blk;
            r_key  <= i_req.key;
        end
        if (m_a) r_hidx_a <= r_pidx[A_AW-1:0];
        if (m_b) r_hidx_b <= r_pidx[B_AW-1:0];
        // lowest free slot wins
        if (f_a && !r_free_a) r_fidx_a <= r_pidx[A_AW-1:0];
        if (f_b && !r_free_b) r_fidx_b <= r_pidx[B_AW-1:0];
    end

endmodule

[design/ipv4_address_and_tcp_flag_filter_unit.sv]
// ----------------------------------------------------------------------------
// ipv4_address_and_tcp_flag_filter_unit
// ipv4 source address allow/block filter with tcp flag sanity checks
// ----------------------------------------------------------------------------
// flow: a frame byte that is not last only updates the header capture; a frame
//   end that fails the ethernet, ethertype or ip length check goes to the fin
//   state and loads its result once the output is free; lookups and table ops
//   first scan: the shared compare reads one entry of both list rams per cycle,
//   then commits; one item is in flight at a time
// reset: synchronous active low; afterwards both list rams are swept clear,
//   one entry per cycle, with o_ready held low
module ipv4_address_and_tcp_flag_filter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_op,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_frame_last,
    input  logic [31:0] i_list_address,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_verdict,
    output logic [2:0]  o_cause,
    output logic [1:0]  o_table_status,
    output logic [63:0] o_total_count,
    output logic [63:0] o_blocked_count,
    output logic [63:0] o_bad_flags_count,
    output logic [63:0] o_fragment_count,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);
    import ipfl_pkg::*;

    t_state      r_state, n_state;
    logic [15:0] r_min_frag;

    // captured header of the frame being judged
    t_hdr        r_snap;
    logic        r_is_frame;
    logic        r_hit_a, r_hit_b;
    t_tstat      r_tstat;

    // result register
    logic        r_ovalid;
    logic        r_verdict;
    t_cause      r_cause;
    t_tstat      r_ostat;
    logic [63:0] r_cnt_total, r_cnt_blk, r_cnt_flag, r_cnt_frag;

    t_hdr        hdr;
    t_scan_req   req;
    t_scan_rsp   rsp;
    logic        in_acc, is_frame, is_table, take, early, out_free, fin_load;
    t_cause      cause;
    logic        bump_blk, bump_flag, bump_frag, is_frag;
    logic [7:0]  tcp_min, fl;

    // header capture
    ipfl_hdr u_hdr (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_take (take),
        .i_byte (i_frame_byte),
        .i_last (i_frame_last),
        .o_hdr  (hdr)
    );

    // list rams and the shared compare
    ipfl_scan u_scan (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req),
        .o_rsp  (rsp)
    );

    assign o_cfg_ready = 1'b1;

    always_comb begin
        o_ready  = r_state == ST_IDLE && rsp.idle;
        in_acc   = i_valid && o_ready;
        is_frame = i_op == OP_FRAME;
        is_table = i_op == OP_ADD_ALLOW || i_op == OP_ADD_BLOCK ||
                   i_op == OP_DEL_ALLOW || i_op == OP_DEL_BLOCK;
        take     = in_acc && is_frame;
        // these checks come before the list lookup, so no scan is needed
        early    = hdr.len < LEN_ETH || hdr.ether != ETH_IPV4 || hdr.len < LEN_IP_MIN;

        req.go   = in_acc && ((is_frame && i_frame_last && !early) || is_table);
        req.blk  = i_op == OP_ADD_BLOCK || i_op == OP_DEL_BLOCK;
        req.key  = is_frame ? hdr.src : i_list_address;
        if (is_frame) begin
            req.kind = SK_LOOKUP;
        end else if (i_op == OP_ADD_ALLOW || i_op == OP_ADD_BLOCK) begin
            req.kind = SK_ADD;
        end else begin
            req.kind = SK_REMOVE;
        end

        out_free = !r_ovalid || i_ready;
        fin_load = r_state == ST_FIN && out_free;

        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (take && i_frame_last) begin
                    n_state = early ? ST_FIN : ST_SCAN;
                end else if (in_acc && is_table) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (rsp.done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // frame judgement, checks in their order of precedence
    always_comb begin
        fl        = r_snap.flags;
        tcp_min   = LEN_IP_MIN + {2'b00, r_snap.hw, 2'b00};
        is_frag   = (r_snap.frag & (FRAG_OFS_MASK | FRAG_MF_BIT)) != 16'd0;
        bump_blk  = 1'b0;
        bump_flag = 1'b0;
        bump_frag = 1'b0;
        priority if (r_snap.len < LEN_ETH) begin
            cause = CAUSE_MALFORMED;
        end else if (r_snap.ether != ETH_IPV4) begin
            cause = CAUSE_NOT_IPV4;
        end else if (r_snap.len < LEN_IP_MIN) begin
            cause = CAUSE_MALFORMED;
        end else if (r_hit_a) begin
            cause = CAUSE_ALLOWED;
        end else if (r_hit_b) begin
            cause    = CAUSE_BLOCKED;
            bump_blk = 1'b1;
        end else if (is_frag && r_snap.tot_len < r_min_frag) begin
            cause     = CAUSE_SHORT_FRG;
            bump_frag = 1'b1;
        end else if (r_snap.hw < 4'd5) begin
            cause = CAUSE_MALFORMED;
        end else if (r_snap.proto == PROTO_TCP && r_snap.len < tcp_min) begin
            cause = CAUSE_MALFORMED;
        end else if (r_snap.proto == PROTO_TCP &&
                     (fl == 8'h00 ||
                      (fl & FL_FIN_PSH_URG) == FL_FIN_PSH_URG ||
                      (fl & FL_SYN_FIN) == FL_SYN_FIN ||
                      (fl & FL_FIN_ACK) == FL_FIN ||
                      (fl & FL_SYN_RST) == FL_SYN_RST)) begin
            cause     = CAUSE_BAD_FLAGS;
            bump_flag = 1'b1;
        end else begin
            cause = CAUSE_CLEAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_min_frag  <= MIN_FRAG_RESET;
            r_ovalid    <= 1'b0;
            r_cnt_total <= '0;
            r_cnt_blk   <= '0;
            r_cnt_flag  <= '0;
            r_cnt_frag  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_min_frag <= i_cfg_data;
            end
            if (fin_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            // saturating event counters, bumped once per frame end
            if (fin_load && r_is_frame) begin
                if (r_cnt_total != '1) r_cnt_total <= r_cnt_total + 64'd1;
                if (bump_blk && r_cnt_blk != '1) r_cnt_blk <= r_cnt_blk + 64'd1;
                if (bump_flag && r_cnt_flag != '1) r_cnt_flag <= r_cnt_flag + 64'd1;
                if (bump_frag && r_cnt_frag != '1) r_cnt_frag <= r_cnt_frag + 64'd1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc && (is_table || (is_frame && i_frame_last))) begin
            r_is_frame <= is_frame;
            r_snap     <= hdr;
            r_hit_a    <= 1'b0;
            r_hit_b    <= 1'b0;
        end else if (rsp.done) begin
            r_hit_a <= rsp.hit_allow;
            r_hit_b <= rsp.hit_block;
            r_tstat <= rsp.status;
        end
        if (fin_load) begin
            if (r_is_frame) begin
                r_cause   <= cause;
                r_verdict <= !(cause == CAUSE_CLEAN || cause == CAUSE_ALLOWED ||
                               cause == CAUSE_NOT_IPV4);
                r_ostat   <= TS_DONE;
            end else begin
                r_cause   <= CAUSE_CLEAN;
                r_verdict <= 1'b0;
                r_ostat   <= r_tstat;
            end
        end
    end

    // counters only move when a new result loads, so they ride on the beat as is
    assign o_valid           = r_ovalid;
    assign o_verdict         = r_verdict;
    assign o_cause           = r_cause;
    assign o_table_status    = r_ostat;
    assign o_total_count     = r_cnt_total;
    assign o_blocked_count   = r_cnt_blk;
    assign o_bad_flags_count = r_cnt_flag;
    assign o_fragment_count  = r_cnt_frag;

    // table results never carry a drop
    a_table_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_table_status != TS_DONE) |-> (!o_verdict && o_cause == CAUSE_CLEAN))
        else $error("table result carries a frame verdict");

    // no input beat while a lookup or result is pending
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_ready)
        else $error("input accepted while busy");

    // blocked frames are always counted in the total
    a_cnt_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_blocked_count <= o_total_count)
        else $error("blocked count above total count");

    // total count never goes backward
    a_cnt_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> o_total_count >= $past(o_total_count))
        else $error("total count decreased");

endmodule

[verif/ipv4_address_and_tcp_flag_filter_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_address_and_tcp_flag_filter_unit_tb
// drives frame bytes and list updates through the filter, predicts each
// verdict, table status and counter set, and compares every result beat
// ----------------------------------------------------------------------------
module ipv4_address_and_tcp_flag_filter_unit_tb;

    import ipfl_pkg::*;

    // one input beat as it goes on the wire
    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  fbyte;
        logic        flast;
        logic [31:0] addr;
    } t_item;

    // one result beat
    typedef struct packed {
        logic        verdict;
        logic [2:0]  cause;
        logic [1:0]  tstat;
        logic [63:0] total;
        logic [63:0] blocked;
        logic [63:0] badfl;
        logic [63:0] frag;
    } t_verdict;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_op;
    logic [7:0]  i_frame_byte;
    logic        i_frame_last;
    logic [31:0] i_list_address;
    logic        o_valid;
    logic        i_ready;
    logic        o_verdict;
    logic [2:0]  o_cause;
    logic [1:0]  o_table_status;
    logic [63:0] o_total_count;
    logic [63:0] o_blocked_count;
    logic [63:0] o_bad_flags_count;
    logic [63:0] o_fragment_count;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;

    ipv4_address_and_tcp_flag_filter_unit u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_op              (i_op),
        .i_frame_byte      (i_frame_byte),
        .i_frame_last      (i_frame_last),
        .i_list_address    (i_list_address),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_verdict         (o_verdict),
        .o_cause           (o_cause),
        .o_table_status    (o_table_status),
        .o_total_count     (o_total_count),
        .o_blocked_count   (o_blocked_count),
        .o_bad_flags_count (o_bad_flags_count),
        .o_fragment_count  (o_fragment_count),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // ------------------------------------------------------------------
    // filter shadow state
    // ------------------------------------------------------------------
    logic [15:0] min_frag_len;
    logic [6:0]  p_idx;
    logic [15:0] p_ether;
    logic [31:0] p_src;
    logic [3:0]  p_hw;
    logic [15:0] p_frag;
    logic [15:0] p_totlen;
    logic [7:0]  p_proto;
    logic [7:0]  p_flags;
    logic [31:0] allow_addr [ALLOW_DEPTH];
    logic        allow_vld  [ALLOW_DEPTH];
    logic [31:0] block_addr [BLOCK_DEPTH];
    logic        block_vld  [BLOCK_DEPTH];
    logic [63:0] cnt_total, cnt_blocked, cnt_badfl, cnt_frag;

    t_item    pending_beats[$];
    t_verdict expected_verdicts[$];
    int       mismatches;
    bit       stim_done;
    bit       hold_sender;

    // known addresses, reused so that list hits are common
    logic [31:0] addr_pool[8];

    function automatic logic [63:0] sat_inc(logic [63:0] v);
        return (v == '1) ? v : v + 64'd1;
    endfunction

    function automatic bit in_allow(logic [31:0] a);
        for (int i = 0; i < ALLOW_DEPTH; i++)
            if (allow_vld[i] && allow_addr[i] == a) return 1'b1;
        return 1'b0;
    endfunction

    function automatic bit in_block(logic [31:0] a);
        for (int i = 0; i < BLOCK_DEPTH; i++)
            if (block_vld[i] && block_addr[i] == a) return 1'b1;
        return 1'b0;
    endfunction

    function automatic void clear_parse();
        p_idx = '0; p_ether = '0; p_src = '0; p_hw = '0;
        p_frag = '0; p_totlen = '0; p_proto = '0; p_flags = '0;
    endfunction

    // parsing of one header byte at the current offset
    function automatic void absorb_byte(logic [7:0] b);
        int i;
        int flag_pos;
        i = p_idx;
        flag_pos = 14 + 4 * p_hw + 13;
        case (i)
            12: p_ether[15:8]  = b;
            13: p_ether[7:0]   = b;
            14: p_hw           = b[3:0];
            16: p_totlen[15:8] = b;
            17: p_totlen[7:0]  = b;
            20: p_frag[15:8]   = b;
            21: p_frag[7:0]    = b;
            23: p_proto        = b;
            26: p_src[31:24]   = b;
            27: p_src[23:16]   = b;
            28: p_src[15:8]    = b;
            29: p_src[7:0]     = b;
            default: ;
        endcase
        if (i > 14 && i == flag_pos) p_flags = b;
        if (p_idx < IDX_MAX) p_idx = p_idx + 7'd1;
    endfunction

    function automatic t_cause judge_frame(int len);
        logic [7:0] f;
        f = p_flags;
        cnt_total = sat_inc(cnt_total);
        if (len < 14) return CAUSE_MALFORMED;
        if (p_ether != ETH_IPV4) return CAUSE_NOT_IPV4;
        if (len < 34) return CAUSE_MALFORMED;
        if (in_allow(p_src)) return CAUSE_ALLOWED;
        if (in_block(p_src)) begin
            cnt_blocked = sat_inc(cnt_blocked);
            return CAUSE_BLOCKED;
        end
        if ((p_frag & (FRAG_OFS_MASK | FRAG_MF_BIT)) != 0 && p_totlen < min_frag_len) begin
            cnt_frag = sat_inc(cnt_frag);
            return CAUSE_SHORT_FRG;
        end
        if (p_hw < 5) return CAUSE_MALFORMED;
        if (p_proto == PROTO_TCP) begin
            if (len < 34 + 4 * p_hw) return CAUSE_MALFORMED;
            if (f == 8'h00 || (f & FL_FIN_PSH_URG) == FL_FIN_PSH_URG
                    || (f & FL_SYN_FIN) == FL_SYN_FIN || (f & FL_FIN_ACK) == FL_FIN
                    || (f & FL_SYN_RST) == FL_SYN_RST) begin
                cnt_badfl = sat_inc(cnt_badfl);
                return CAUSE_BAD_FLAGS;
            end
        end
        return CAUSE_CLEAN;
    endfunction

    function automatic t_tstat list_insert(bit blk, logic [31:0] a);
        if (blk ? in_block(a) : in_allow(a)) return TS_DONE;
        for (int i = 0; i < (blk ? BLOCK_DEPTH : ALLOW_DEPTH); i++) begin
            if (blk && !block_vld[i]) begin
                block_vld[i] = 1'b1; block_addr[i] = a; return TS_DONE;
            end
            if (!blk && !allow_vld[i]) begin
                allow_vld[i] = 1'b1; allow_addr[i] = a; return TS_DONE;
            end
        end
        return TS_FULL;
    endfunction

    function automatic t_tstat list_delete(bit blk, logic [31:0] a);
        for (int i = 0; i < (blk ? BLOCK_DEPTH : ALLOW_DEPTH); i++) begin
            if (blk && block_vld[i] && block_addr[i] == a) begin
                block_vld[i] = 1'b0; return TS_DONE;
            end
            if (!blk && allow_vld[i] && allow_addr[i] == a) begin
                allow_vld[i] = 1'b0; return TS_DONE;
            end
        end
        return TS_NOT_FOUND;
    endfunction

    // predicts the result of one accepted beat, if it makes one
    function automatic void predict_beat(t_item it);
        t_verdict r;
        int       len;
        r = '0;
        case (it.op)
            OP_FRAME: begin
                absorb_byte(it.fbyte);
                if (!it.flast) return;
                len = (p_idx >= IDX_MAX) ? 128 : int'(p_idx);
                r.cause = judge_frame(len);
                r.verdict = !(r.cause inside {CAUSE_CLEAN, CAUSE_ALLOWED, CAUSE_NOT_IPV4});
                clear_parse();
            end
            OP_ADD_ALLOW: r.tstat = list_insert(1'b0, it.addr);
            OP_ADD_BLOCK: r.tstat = list_insert(1'b1, it.addr);
            OP_DEL_ALLOW: r.tstat = list_delete(1'b0, it.addr);
            OP_DEL_BLOCK: r.tstat = list_delete(1'b1, it.addr);
            default: return;
        endcase
        r.total = cnt_total; r.blocked = cnt_blocked;
        r.badfl = cnt_badfl; r.frag = cnt_frag;
        expected_verdicts.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------
    function automatic t_item table_beat(t_op op, logic [31:0] a);
        t_item it;
        it.op = op; it.addr = a;
        it.fbyte = 8'($urandom); it.flast = 1'($urandom);
        return it;
    endfunction

    function automatic void push_byte(logic [7:0] b, bit last);
        t_item it;
        it.op = OP_FRAME; it.fbyte = b; it.flast = last;
        it.addr = $urandom;
        pending_beats.push_back(it);
    endfunction

    // queue a frame with an ipv4/tcp header built from the given fields
    function automatic void push_frame(int len, logic [15:0] ether, logic [7:0] verihl,
            logic [15:0] totlen, logic [15:0] frag, logic [7:0] proto,
            logic [31:0] src, logic [7:0] flags);
        logic [7:0] b;
        int fpos;
        fpos = 27 + 4 * verihl[3:0];
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom);
            case (i)
                12: b = ether[15:8];
                13: b = ether[7:0];
                14: b = verihl;
                16: b = totlen[15:8];
                17: b = totlen[7:0];
                20: b = frag[15:8];
                21: b = frag[7:0];
                23: b = proto;
                26: b = src[31:24];
                27: b = src[23:16];
                28: b = src[15:8];
                29: b = src[7:0];
                default: ;
            endcase
            if (i == fpos && i > 14) b = flags;
            push_byte(b, i == len - 1);
        end
    endfunction

    function automatic void push_random_frame();
        int          len;
        logic [7:0]  verihl;
        logic [7:0]  flags;
        logic [15:0] frag;
        logic [15:0] ether;
        logic [7:0]  proto;
        verihl = ($urandom_range(0, 9) == 0) ? 8'($urandom) : {4'h4, 4'($urandom_range(5, 8))};
        case ($urandom_range(0, 9))
            0:       len = $urandom_range(1, 13);
            1:       len = $urandom_range(14, 40);
            2:       len = $urandom_range(130, 150);
            default: len = 34 + 4 * verihl[3:0] + $urandom_range(0, 12);
        endcase
        ether = ($urandom_range(0, 7) == 0) ? 16'($urandom) : ETH_IPV4;
        proto = ($urandom_range(0, 3) == 0) ? 8'($urandom) : PROTO_TCP;
        frag  = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'h4000;
        flags = ($urandom_range(0, 2) == 0) ? 8'($urandom)
                                            : 8'({$urandom_range(0, 7), 2'b0, 3'b000} | 8'h10);
        push_frame(len, ether, verihl, 16'($urandom), frag, proto,
                   addr_pool[$urandom_range(0, 7)] ^ (($urandom_range(0, 3) == 0) ? $urandom : 0),
                   flags);
    endfunction

    function automatic void push_random_table();
        pending_beats.push_back(table_beat(t_op'($urandom_range(OP_ADD_ALLOW, OP_DEL_BLOCK)),
            ($urandom_range(0, 4) == 0) ? $urandom : addr_pool[$urandom_range(0, 7)]));
    endfunction

    // ------------------------------------------------------------------
    // driver: pops pending beats, random gaps between them
    // ------------------------------------------------------------------
    int gap_left;

    function automatic int pick_gap();
        case ($urandom_range(0, 19))
            0:       return $urandom_range(10, 40);
            1, 2, 3: return $urandom_range(1, 3);
            default: return 0;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            gap_left <= 0;
        end else begin
            if (i_valid && o_ready) predict_beat({i_op, i_frame_byte, i_frame_last, i_list_address});
            if (!i_valid || o_ready) begin
                if (gap_left > 0 || hold_sender || pending_beats.size() == 0) begin
                    i_valid <= 1'b0;
                    if (gap_left > 0) gap_left <= gap_left - 1;
                end else begin
                    t_item it;
                    it = pending_beats.pop_front();
                    i_valid        <= 1'b1;
                    i_op           <= it.op;
                    i_frame_byte   <= it.fbyte;
                    i_frame_last   <= it.flast;
                    i_list_address <= it.addr;
                    gap_left       <= pick_gap();
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: random backpressure, compares each result beat
    // ------------------------------------------------------------------
    int stall_left;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_valid && i_ready) begin
                t_verdict got, want;
                got = {o_verdict, o_cause, o_table_status, o_total_count,
                       o_blocked_count, o_bad_flags_count, o_fragment_count};
                if (expected_verdicts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result beat %h", got);
                end else begin
                    want = expected_verdicts.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected v%0d c%0d s%0d %0d/%0d/%0d/%0d, got v%0d c%0d s%0d %0d/%0d/%0d/%0d",
                                want.verdict, want.cause, want.tstat, want.total, want.blocked,
                                want.badfl, want.frag, got.verdict, got.cause, got.tstat,
                                got.total, got.blocked, got.badfl, got.frag);
                    end
                end
            end
            if (stall_left > 0) begin
                i_ready    <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                i_ready    <= 1'b1;
                stall_left <= pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // phases
    // ------------------------------------------------------------------
    task automatic wait_drained();
        while (pending_beats.size() != 0 || i_valid || expected_verdicts.size() != 0)
            @(posedge i_clk);
        // a non-last byte may still be in flight
        repeat (SCAN_DEPTH + 20) @(posedge i_clk);
    endtask

    task automatic write_min_frag(logic [15:0] v);
        i_cfg_data  <= v;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        min_frag_len = v;
        i_cfg_valid <= 1'b0;
    endtask

    logic [15:0] cfg_settings[4] = '{16'd0, 16'hFFFF, 16'd600, MIN_FRAG_RESET};

    initial begin
        i_rst_n = 1'b0; i_valid = 1'b0; i_ready = 1'b0;
        i_op = '0; i_frame_byte = '0; i_frame_last = 1'b0; i_list_address = '0;
        i_cfg_valid = 1'b0; i_cfg_data = '0;
        mismatches = 0; stim_done = 1'b0; hold_sender = 1'b0;
        min_frag_len = MIN_FRAG_RESET;
        clear_parse();
        for (int i = 0; i < ALLOW_DEPTH; i++) allow_vld[i] = 1'b0;
        for (int i = 0; i < BLOCK_DEPTH; i++) block_vld[i] = 1'b0;
        cnt_total = '0; cnt_blocked = '0; cnt_badfl = '0; cnt_frag = '0;
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 8; i++) addr_pool[i] = $urandom;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: table corner cases and every cause
        pending_beats.push_back(table_beat(OP_DEL_ALLOW, addr_pool[1]));
        pending_beats.push_back(table_beat(OP_ADD_ALLOW, addr_pool[1]));
        pending_beats.push_back(table_beat(OP_ADD_ALLOW, addr_pool[1]));
        pending_beats.push_back(table_beat(OP_ADD_BLOCK, addr_pool[0]));
        pending_beats.push_back(table_beat(OP_DEL_BLOCK, addr_pool[2]));
        pending_beats.push_back(table_beat(t_op'(3'd5), 32'h0));
        pending_beats.push_back(table_beat(t_op'(3'd7), 32'hFFFF_FFFF));
        push_frame(1, 0, 0, 0, 0, 0, 0, 0);
        push_frame(13, 0, 0, 0, 0, 0, 0, 0);
        push_frame(14, 16'h86DD, 8'h45, 0, 0, 0, 0, 0);
        push_frame(33, ETH_IPV4, 8'h45, 0, 0, PROTO_TCP, addr_pool[3], 8'h12);
        push_frame(34, ETH_IPV4, 8'h45, 0, 0, PROTO_TCP, addr_pool[1], 8'h00);
        push_frame(34, ETH_IPV4, 8'h45, 0, 0, PROTO_TCP, addr_pool[0], 8'h12);
        push_frame(34, ETH_IPV4, 8'h45, 16'd100, 16'h2000, PROTO_TCP, addr_pool[3], 8'h12);
        push_frame(34, ETH_IPV4, 8'h45, 16'd100, 16'h1FFF, 8'h11, addr_pool[3], 8'h12);
        push_frame(34, ETH_IPV4, 8'h44, 0, 16'h4000, PROTO_TCP, addr_pool[3], 8'h12);
        push_frame(50, ETH_IPV4, 8'h4F, 0, 16'h4000, PROTO_TCP, addr_pool[3], 8'h12);
        foreach (cfg_settings[k]) begin
            logic [7:0] fl;
            fl = (k == 0) ? 8'h00 : (k == 1) ? 8'h29 : (k == 2) ? 8'h03 : 8'h06;
            push_frame(54, ETH_IPV4, 8'h45, 0, 0, PROTO_TCP, addr_pool[4], fl);
        end
        push_frame(54, ETH_IPV4, 8'h45, 0, 0, PROTO_TCP, addr_pool[4], 8'h01);
        push_frame(54, ETH_IPV4, 8'h45, 0, 0, PROTO_TCP, addr_pool[4], 8'h11);
        push_frame(140, ETH_IPV4, 8'h4F, 16'hFFFF, 16'hDFFF, PROTO_TCP, addr_pool[5], 8'hFF);
        wait_drained();

        // random phases over several thresholds
        foreach (cfg_settings[k]) begin
            write_min_frag(cfg_settings[k]);
            for (int n = 0; n < 2; n++) begin
                if ($urandom_range(0, 3) == 0) push_random_table();
                else push_random_frame();
                if (n == 0 && k == 1) begin
                    // sender holds off until every result is back
                    while (pending_beats.size() != 0 || i_valid) @(posedge i_clk);
                    hold_sender = 1'b1;
                    while (expected_verdicts.size() != 0) @(posedge i_clk);
                    hold_sender = 1'b0;
                end
            end
            wait_drained();
        end
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        if (mismatches == 0 && expected_verdicts.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #40ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
